@@ hdl/fcrd_pkg.sv @@
// Package for the framed command receiver with dead-man timeout.
// Holds the word types of both channels, register indexes and framing constants.
// No dependencies.
package fcrd_pkg;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic       laser0_on;
      logic       laser1_on;
      logic [7:0] motor0_reverse;
      logic [7:0] motor0_forward;
      logic [7:0] motor1_reverse;
      logic [7:0] motor1_forward;
      logic [7:0] frame_rate;
      logic       message_done;
      logic       deadman_expired;
   } rsp_word_type;

   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned INDEX_WIDTH     = 10;
   localparam int unsigned PAYLOAD_DEPTH   = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEADMAN_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEADMAN_LIMIT  = 1'd1;

   localparam logic [7:0] HDR_A     = 8'hFF;
   localparam logic [7:0] HDR_B     = 8'h00;
   localparam logic [7:0] TYPE_DATA = 8'd1;
   localparam logic [7:0] TYPE_SKIP = 8'd2;
   localparam logic [7:0] FULL_HIGH = 8'd255;
   localparam logic [7:0] LASER_OFF = 8'd0;
   localparam logic [7:0] LASER_ON  = 8'd1;
   localparam logic [7:0] FPS_RESET = 8'd2;

   localparam logic [INDEX_WIDTH-1:0] FIRST_PAYLOAD = 10'd5;
   localparam logic [INDEX_WIDTH-1:0] PAYLOAD_END   = 10'd13;
   localparam logic [INDEX_WIDTH-1:0] TYPE_DATA_END = 10'd12;
   localparam logic [INDEX_WIDTH-1:0] TYPE_SKIP_END = 10'd999;

   localparam logic [CSR_DATA_WIDTH-1:0] LIMIT_RESET = 16'd5000;

endpackage

@@ hdl/framed_command_receiver_with_deadman_unit.sv @@
// Top level of the framed command receiver with dead-man timeout.
// Depends on fcrd_pkg for the word types and framing constants.
//
// Usage: each request word is either a received serial byte (command 0) or a
// main loop tick (command 1). Bytes are searched for the header FF 00 FF 00;
// the following type byte starts a message, and a type 1 message updates the
// frame rate, laser commands and motor speeds. Each tick applies the stored
// commands to the laser pins and motor duties, or forces them off when the
// dead-man counter has expired and the dead-man is enabled.
// Every request word produces exactly one response word. One request word is
// accepted per cycle while req_stall is low; the rate is set by the single
// pass of decode logic between the request and the response register. A skid
// register lets one further word be accepted while a response is stalled;
// req_stall rises only when both are occupied. Reset is synchronous: the
// registers return to their reset values (dead-man enabled, limit 5000, frame
// rate 2) and no response is pending. Configuration writes on the csr_ port
// take effect from the next cycle; the user must make them only while the
// unit is idle, as the unit itself does not enforce this.
module framed_command_receiver_with_deadman_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  fcrd_pkg::req_word_type                 req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output fcrd_pkg::rsp_word_type                 rsp_word,
   input  logic                                   csr_write,
   input  logic [fcrd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [fcrd_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int unsigned IW = fcrd_pkg::INDEX_WIDTH;
   localparam int unsigned DW = fcrd_pkg::CSR_DATA_WIDTH;

   logic                 enable_ff, enable_in;
   logic [DW-1:0]        limit_ff, limit_in;
   logic [7:0]           window_ff [4];
   logic [7:0]           window_in [4];
   logic                 collecting_ff, collecting_in;
   logic [IW-1:0]        byte_index_ff, byte_index_in;
   logic [IW-1:0]        end_index_ff, end_index_in;
   logic [7:0]           payload_ff [fcrd_pkg::PAYLOAD_DEPTH];
   logic [7:0]           payload_in [fcrd_pkg::PAYLOAD_DEPTH];
   logic [7:0]           fps_ff, fps_in;
   logic [7:0]           laser_cmd_ff [2];
   logic [7:0]           laser_cmd_in [2];
   logic signed [8:0]    speed_ff [2];
   logic signed [8:0]    speed_in [2];
   logic                 pin_ff [2];
   logic                 pin_in [2];
   logic [7:0]           duty_ff [4];
   logic [7:0]           duty_in [4];
   logic [DW-1:0]        ticks_ff, ticks_in;

   logic                 req_accept;
   logic                 header_seen;
   logic                 done;
   logic                 expired;
   logic [IW-1:0]        index_step;
   logic [IW-1:0]        payload_offset;
   logic signed [8:0]    speed_neg [2];
   fcrd_pkg::rsp_word_type result;

   logic                 out_valid_ff;
   fcrd_pkg::rsp_word_type out_ff;
   logic                 skid_valid_ff;
   fcrd_pkg::rsp_word_type skid_ff;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_word   = out_ff;

   assign header_seen = (window_ff[0] == fcrd_pkg::HDR_A) && (window_ff[1] == fcrd_pkg::HDR_B)
                        && (window_ff[2] == fcrd_pkg::HDR_A)
                        && (window_ff[3] == fcrd_pkg::HDR_B);
   assign payload_offset = byte_index_ff - fcrd_pkg::FIRST_PAYLOAD;
   assign speed_neg[0]   = -speed_ff[0];
   assign speed_neg[1]   = -speed_ff[1];

   always_comb begin
      enable_in     = enable_ff;
      limit_in      = limit_ff;
      window_in     = window_ff;
      collecting_in = collecting_ff;
      byte_index_in = byte_index_ff;
      end_index_in  = end_index_ff;
      payload_in    = payload_ff;
      fps_in        = fps_ff;
      laser_cmd_in  = laser_cmd_ff;
      speed_in      = speed_ff;
      pin_in        = pin_ff;
      duty_in       = duty_ff;
      ticks_in      = ticks_ff;
      index_step    = byte_index_ff;
      done          = 1'b0;
      expired       = 1'b0;

      if (csr_write) begin
         case (csr_index)
            fcrd_pkg::CSR_DEADMAN_ENABLE: enable_in = csr_wdata[0];
            fcrd_pkg::CSR_DEADMAN_LIMIT:  limit_in  = csr_wdata;
            default: ;
         endcase
      end

      if (req_accept) begin
         if (!req_word.command) begin
            if (!collecting_ff) begin
               window_in[0] = window_ff[1];
               window_in[1] = window_ff[2];
               window_in[2] = window_ff[3];
               window_in[3] = req_word.rx_byte;
               if (header_seen) begin
                  collecting_in = 1'b1;
                  byte_index_in = fcrd_pkg::FIRST_PAYLOAD;
                  if (req_word.rx_byte == fcrd_pkg::TYPE_DATA) begin
                     end_index_in = fcrd_pkg::TYPE_DATA_END;
                  end else if (req_word.rx_byte == fcrd_pkg::TYPE_SKIP) begin
                     end_index_in = fcrd_pkg::TYPE_SKIP_END;
                  end
               end
            end else begin
               if (byte_index_ff <= end_index_ff) begin
                  if (byte_index_ff >= fcrd_pkg::FIRST_PAYLOAD
                      && byte_index_ff < fcrd_pkg::PAYLOAD_END) begin
                     payload_in[payload_offset[2:0]] = req_word.rx_byte;
                  end
                  index_step = byte_index_ff + 10'd1;
               end
               byte_index_in = index_step;
               if (index_step > end_index_ff) begin
                  collecting_in = 1'b0;
                  done          = 1'b1;
                  ticks_in      = '0;
                  if (window_ff[3] == fcrd_pkg::TYPE_DATA) begin
                     fps_in          = payload_ff[0];
                     laser_cmd_in[0] = payload_ff[1];
                     laser_cmd_in[1] = payload_ff[4];
                     speed_in[0] = (payload_ff[3] == fcrd_pkg::FULL_HIGH)
                                   ? $signed({1'b0, payload_ff[2]})
                                   : -$signed({1'b0, payload_ff[2]});
                     speed_in[1] = (payload_ff[6] == fcrd_pkg::FULL_HIGH)
                                   ? $signed({1'b0, payload_ff[5]})
                                   : -$signed({1'b0, payload_ff[5]});
                  end
               end
            end
            expired = ticks_in >= limit_ff;
         end else begin
            expired = ticks_ff >= limit_ff;
            if (enable_ff && expired) begin
               pin_in[0] = 1'b0;
               pin_in[1] = 1'b0;
               duty_in[0] = '0;
               duty_in[1] = '0;
               duty_in[2] = '0;
               duty_in[3] = '0;
            end else begin
               for (int k = 0; k < 2; k++) begin
                  if (laser_cmd_ff[k] == fcrd_pkg::LASER_ON) begin
                     pin_in[k] = 1'b1;
                  end else if (laser_cmd_ff[k] == fcrd_pkg::LASER_OFF) begin
                     pin_in[k] = 1'b0;
                  end
                  if (speed_ff[k][8]) begin
                     duty_in[2*k]   = speed_neg[k][7:0];
                     duty_in[2*k+1] = '0;
                  end else begin
                     duty_in[2*k]   = '0;
                     duty_in[2*k+1] = speed_ff[k][7:0];
                  end
               end
            end
            if (ticks_ff < limit_ff) begin
               ticks_in = ticks_ff + 16'd1;
            end else begin
               ticks_in = limit_ff;
            end
         end
      end

      result.laser0_on       = pin_in[0];
      result.laser1_on       = pin_in[1];
      result.motor0_reverse  = duty_in[0];
      result.motor0_forward  = duty_in[1];
      result.motor1_reverse  = duty_in[2];
      result.motor1_forward  = duty_in[3];
      result.frame_rate      = fps_in;
      result.message_done    = done;
      result.deadman_expired = expired;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b1;
         limit_ff      <= fcrd_pkg::LIMIT_RESET;
         window_ff     <= '{default: '0};
         collecting_ff <= 1'b0;
         byte_index_ff <= '0;
         end_index_ff  <= '0;
         fps_ff        <= fcrd_pkg::FPS_RESET;
         laser_cmd_ff  <= '{default: '0};
         speed_ff      <= '{default: '0};
         pin_ff        <= '{default: 1'b0};
         duty_ff       <= '{default: '0};
         ticks_ff      <= '0;
      end else begin
         enable_ff     <= enable_in;
         limit_ff      <= limit_in;
         window_ff     <= window_in;
         collecting_ff <= collecting_in;
         byte_index_ff <= byte_index_in;
         end_index_ff  <= end_index_in;
         fps_ff        <= fps_in;
         laser_cmd_ff  <= laser_cmd_in;
         speed_ff      <= speed_in;
         pin_ff        <= pin_in;
         duty_ff       <= duty_in;
         ticks_ff      <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_accept) begin
            out_ff <= result;
         end
      end else if (req_accept) begin
         skid_ff <= result;
      end
   end

endmodule
